[sv/cgv_pkg.sv]
package cgv_pkg;

  // Largest grid dimension along either axis of a face.
  localparam int MaxGridDef = 255;

  // Width of the divider dividend: a 9-bit magnitude times a 31-bit extent.
  localparam int DivW = 40;

  // Division operations, run one after the other for each vertex.
  localparam logic [1:0] OP_A = 2'd0;  // in-plane coordinate across columns
  localparam logic [1:0] OP_B = 2'd1;  // in-plane coordinate across rows
  localparam logic [1:0] OP_U = 2'd2;  // texture u
  localparam logic [1:0] OP_V = 2'd3;  // texture v

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_X_EXT  = 3'd0;
  localparam logic [2:0] REG_Y_EXT  = 3'd1;
  localparam logic [2:0] REG_Z_EXT  = 3'd2;
  localparam logic [2:0] REG_YZ_RES = 3'd3;
  localparam logic [2:0] REG_XZ_RES = 3'd4;
  localparam logic [2:0] REG_XY_RES = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;     // capture a new item and advance the walk
    logic       restart;  // restart bit of the captured item
    logic       prep;     // load the divider for the selected operation
    logic       step;     // one restoring division step
    logic       save;     // store the quotient of the selected operation
    logic       emit;     // load the output register
    logic [1:0] op;       // selected operation
  } cmd_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [30:0] x_ext;
    logic [30:0] y_ext;
    logic [30:0] z_ext;
    logic [15:0] yz_res;
    logic [15:0] xz_res;
    logic [15:0] xy_res;
  } cfg_t;

endpackage

[sv/cgv_regs.sv]
module cgv_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cgv_pkg::cfg_t      cfg
);

  cgv_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_ext  <= 31'd65536;
      cfg_r.y_ext  <= 31'd65536;
      cfg_r.z_ext  <= 31'd65536;
      cfg_r.yz_res <= 16'd514;
      cfg_r.xz_res <= 16'd514;
      cfg_r.xy_res <= 16'd514;
    end else if (wr_en) begin
      case (idx)
        cgv_pkg::REG_X_EXT:  cfg_r.x_ext  <= pwdata[30:0];
        cgv_pkg::REG_Y_EXT:  cfg_r.y_ext  <= pwdata[30:0];
        cgv_pkg::REG_Z_EXT:  cfg_r.z_ext  <= pwdata[30:0];
        cgv_pkg::REG_YZ_RES: cfg_r.yz_res <= pwdata[15:0];
        cgv_pkg::REG_XZ_RES: cfg_r.xz_res <= pwdata[15:0];
        cgv_pkg::REG_XY_RES: cfg_r.xy_res <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (idx)
      cgv_pkg::REG_X_EXT:  prdata = {1'b0, cfg_r.x_ext};
      cgv_pkg::REG_Y_EXT:  prdata = {1'b0, cfg_r.y_ext};
      cgv_pkg::REG_Z_EXT:  prdata = {1'b0, cfg_r.z_ext};
      cgv_pkg::REG_YZ_RES: prdata = {16'd0, cfg_r.yz_res};
      cgv_pkg::REG_XZ_RES: prdata = {16'd0, cfg_r.xz_res};
      cgv_pkg::REG_XY_RES: prdata = {16'd0, cfg_r.xy_res};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

[sv/cgv_ctrl.sv]
module cgv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_restart,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cgv_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SAVE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int          StepW   = $clog2(cgv_pkg::DivW);
  localparam logic [StepW-1:0] LastStep = StepW'(cgv_pkg::DivW - 1);

  logic [2:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             take, emit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign take      = in_valid & in_ready;
  assign emit      = (state_r == S_FIN) & (~out_valid_r | out_ready);

  assign cmd.take    = take;
  assign cmd.restart = in_restart;
  assign cmd.prep    = (state_r == S_PREP);
  assign cmd.step    = (state_r == S_DIV);
  assign cmd.save    = (state_r == S_SAVE);
  assign cmd.emit    = emit;
  assign cmd.op      = op_r;

  // Sequencer: four divisions per vertex, then the result is handed out.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_PREP;
          op_nxt    = cgv_pkg::OP_A;
        end
      end
      S_PREP: begin
        state_nxt = S_DIV;
        step_nxt  = '0;
      end
      S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LastStep) begin
          state_nxt = S_SAVE;
        end
      end
      S_SAVE: begin
        if (op_r == cgv_pkg::OP_V) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PREP;
          op_nxt    = op_r + 1'b1;
        end
      end
      S_FIN: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output beat stays valid until the sink takes it.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      op_r        <= cgv_pkg::OP_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/cgv_dp.sv]
module cgv_dp #(
  parameter int MAX_GRID = cgv_pkg::MaxGridDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cgv_pkg::cmd_t cmd,
  input  cgv_pkg::cfg_t cfg,
  output logic [31:0]   pos_x,
  output logic [31:0]   pos_y,
  output logic [31:0]   pos_z,
  output logic [16:0]   tex_u,
  output logic [16:0]   tex_v,
  output logic [1:0]    normal_x,
  output logic [1:0]    normal_y,
  output logic [1:0]    normal_z,
  output logic [1:0]    tangent_x,
  output logic [1:0]    tangent_z,
  output logic          last_vertex
);

  localparam int          DivW    = cgv_pkg::DivW;
  localparam logic [7:0]  MaxDim  = 8'(MAX_GRID);

  // Walk counters.
  logic [2:0] face_cnt_r, face_cnt_nxt;
  logic [7:0] row_cnt_r, row_cnt_nxt;
  logic [7:0] col_cnt_r, col_cnt_nxt;

  // Captured item.
  logic [2:0] face_r;
  logic [7:0] i_r, j_r, dc_r, dr_r;
  logic       last_r;

  // Divider and quotients.
  logic [DivW-1:0] dvd_r;
  logic [8:0]      rem_r, dsr_r;
  logic [30:0]     qa_r, qb_r;
  logic [16:0]     qu_r, qv_r;
  logic            sa_r, sb_r;

  // Output register.
  logic [31:0] px_r, py_r, pz_r;
  logic [16:0] tu_r, tv_r;
  logic [1:0]  nx_r, ny_r, nz_r, tx_r, tz_r;
  logic        lv_r;

  // Combinational helpers.
  logic [2:0]  face_in, face_c;
  logic [7:0]  row_in, col_in;
  logic [15:0] res_c;
  logic [7:0]  cols_c, rows_c, dc_c, dr_c, r_c, c_c, i_c, j_c;
  logic        last_col, last_row;
  logic [30:0] ew_c, eh_c, en_c;
  logic [8:0]  two_i, two_j, mag_a, mag_b;
  logic        neg_a, neg_b;
  logic [7:0]  ku_c, du_c, kv_c, dv_c;
  logic [DivW-1:0] dvd_c;
  logic [8:0]      dsr_c;
  logic [9:0]      trial;
  logic [9:0]      diff;
  logic [31:0]     a_c, b_c, plane_c;

  function automatic logic [7:0] clamp_dim(input logic [7:0] n);
    if (n < 8'd2) begin
      return 8'd2;
    end else if (n > MaxDim) begin
      return MaxDim;
    end
    return n;
  endfunction

  // Item setup: restart override, face decode and clamping.
  always_comb begin
    face_in = cmd.restart ? 3'd0 : face_cnt_r;
    row_in  = cmd.restart ? 8'd0 : row_cnt_r;
    col_in  = cmd.restart ? 8'd0 : col_cnt_r;
    face_c  = (face_in > 3'd5) ? 3'd0 : face_in;
    if (face_c < 3'd2) begin
      res_c = cfg.yz_res;
    end else if (face_c < 3'd4) begin
      res_c = cfg.xz_res;
    end else begin
      res_c = cfg.xy_res;
    end
    cols_c = clamp_dim(res_c[7:0]);
    rows_c = clamp_dim(res_c[15:8]);
    dc_c   = cols_c - 8'd1;
    dr_c   = rows_c - 8'd1;
    r_c    = (row_in > dr_c) ? dr_c : row_in;
    c_c    = (col_in > dc_c) ? dc_c : col_in;
    j_c    = (face_c == 3'd1 || face_c == 3'd2) ? (dr_c - r_c) : r_c;
    i_c    = (face_c == 3'd5) ? (dc_c - c_c) : c_c;
    last_col = (c_c >= dc_c);
    last_row = (r_c >= dr_c);
  end

  // Next walk position: columns inner, rows outer, then the next face.
  always_comb begin
    if (!last_col) begin
      col_cnt_nxt  = c_c + 8'd1;
      row_cnt_nxt  = r_c;
      face_cnt_nxt = face_c;
    end else if (!last_row) begin
      col_cnt_nxt  = 8'd0;
      row_cnt_nxt  = r_c + 8'd1;
      face_cnt_nxt = face_c;
    end else begin
      col_cnt_nxt  = 8'd0;
      row_cnt_nxt  = 8'd0;
      face_cnt_nxt = (face_c >= 3'd5) ? 3'd0 : face_c + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_cnt_r <= 3'd0;
      row_cnt_r  <= 8'd0;
      col_cnt_r  <= 8'd0;
    end else if (cmd.take) begin
      face_cnt_r <= face_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      face_r <= face_c;
      i_r    <= i_c;
      j_r    <= j_c;
      dc_r   <= dc_c;
      dr_r   <= dr_c;
      last_r <= (face_c == 3'd5) & last_row & last_col;
    end
  end

  // Extents of the captured face.
  always_comb begin
    if (face_r < 3'd2) begin
      ew_c = cfg.y_ext; eh_c = cfg.z_ext; en_c = cfg.x_ext;
    end else if (face_r < 3'd4) begin
      ew_c = cfg.x_ext; eh_c = cfg.z_ext; en_c = cfg.y_ext;
    end else begin
      ew_c = cfg.x_ext; eh_c = cfg.y_ext; en_c = cfg.z_ext;
    end
  end

  // Magnitude and sign of 2k-(n-1) for both in-plane coordinates.
  always_comb begin
    two_i = {i_r, 1'b0};
    two_j = {j_r, 1'b0};
    neg_a = (two_i < {1'b0, dc_r});
    neg_b = (two_j < {1'b0, dr_r});
    mag_a = neg_a ? ({1'b0, dc_r} - two_i) : (two_i - {1'b0, dc_r});
    mag_b = neg_b ? ({1'b0, dr_r} - two_j) : (two_j - {1'b0, dr_r});
  end

  // Texture numerators and denominators, with the per-face flips.
  always_comb begin
    ku_c = i_r;  du_c = dc_r;
    kv_c = j_r;  dv_c = dr_r;
    case (face_r)
      3'd0: begin
        ku_c = dr_r - j_r; du_c = dr_r; kv_c = i_r; dv_c = dc_r;
      end
      3'd1: begin
        ku_c = j_r; du_c = dr_r; kv_c = i_r; dv_c = dc_r;
      end
      3'd2: begin
        kv_c = dr_r - j_r;
      end
      3'd5: begin
        ku_c = dc_r - i_r;
      end
      default: ;
    endcase
  end

  // Dividend and divisor of the selected operation: floor((N + d) / 2d).
  // The product is a 9-bit magnitude times a 31-bit extent, kept at full width.
  always_comb begin
    case (cmd.op)
      cgv_pkg::OP_A: begin
        dvd_c = DivW'(mag_a) * DivW'(ew_c) + DivW'(dc_r);
        dsr_c = {dc_r, 1'b0};
      end
      cgv_pkg::OP_B: begin
        dvd_c = DivW'(mag_b) * DivW'(eh_c) + DivW'(dr_r);
        dsr_c = {dr_r, 1'b0};
      end
      cgv_pkg::OP_U: begin
        dvd_c = DivW'({ku_c, 17'd0}) + DivW'(du_c);
        dsr_c = {du_c, 1'b0};
      end
      default: begin
        dvd_c = DivW'({kv_c, 17'd0}) + DivW'(dv_c);
        dsr_c = {dv_c, 1'b0};
      end
    endcase
  end

  // Restoring division, one quotient bit per step.
  assign trial = {rem_r, dvd_r[DivW-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dvd_r <= dvd_c;
      dsr_r <= dsr_c;
      rem_r <= 9'd0;
    end else if (cmd.step) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_r <= diff[8:0];
        dvd_r <= {dvd_r[DivW-2:0], 1'b1};
      end else begin
        rem_r <= trial[8:0];
        dvd_r <= {dvd_r[DivW-2:0], 1'b0};
      end
    end
  end

  // Quotient capture.
  always_ff @(posedge clk) begin
    if (cmd.save) begin
      case (cmd.op)
        cgv_pkg::OP_A: begin
          qa_r <= dvd_r[30:0];
          sa_r <= neg_a;
        end
        cgv_pkg::OP_B: begin
          qb_r <= dvd_r[30:0];
          sb_r <= neg_b;
        end
        cgv_pkg::OP_U: qu_r <= dvd_r[16:0];
        default:       qv_r <= dvd_r[16:0];
      endcase
    end
  end

  // Signed coordinates and the plane offset.
  always_comb begin
    a_c     = sa_r ? (32'd0 - {1'b0, qa_r}) : {1'b0, qa_r};
    b_c     = sb_r ? (32'd0 - {1'b0, qb_r}) : {1'b0, qb_r};
    plane_c = ({1'b0, en_c} + 32'd1) >> 1;
    if (face_r[0]) begin
      plane_c = 32'd0 - plane_c;
    end
  end

  // Output register, loaded once per vertex.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tu_r <= qu_r;
      tv_r <= qv_r;
      lv_r <= last_r;
      nx_r <= 2'b00; ny_r <= 2'b00; nz_r <= 2'b00;
      tx_r <= 2'b00; tz_r <= 2'b00;
      case (face_r)
        3'd0: begin
          px_r <= plane_c; py_r <= a_c; pz_r <= b_c;
          nx_r <= 2'b01; tz_r <= 2'b11;
        end
        3'd1: begin
          px_r <= plane_c; py_r <= a_c; pz_r <= b_c;
          nx_r <= 2'b11; tz_r <= 2'b01;
        end
        3'd2: begin
          px_r <= a_c; py_r <= plane_c; pz_r <= b_c;
          ny_r <= 2'b01; tx_r <= 2'b01;
        end
        3'd3: begin
          px_r <= a_c; py_r <= plane_c; pz_r <= b_c;
          ny_r <= 2'b11; tx_r <= 2'b01;
        end
        3'd4: begin
          px_r <= a_c; py_r <= b_c; pz_r <= plane_c;
          nz_r <= 2'b01; tx_r <= 2'b01;
        end
        default: begin
          px_r <= a_c; py_r <= b_c; pz_r <= plane_c;
          nz_r <= 2'b11; tx_r <= 2'b11;
        end
      endcase
    end
  end

  assign pos_x       = px_r;
  assign pos_y       = py_r;
  assign pos_z       = pz_r;
  assign tex_u       = tu_r;
  assign tex_v       = tv_r;
  assign normal_x    = nx_r;
  assign normal_y    = ny_r;
  assign normal_z    = nz_r;
  assign tangent_x   = tx_r;
  assign tangent_z   = tz_r;
  assign last_vertex = lv_r;

endmodule

[sv/cuboid_grid_vertex_generator.sv]
// Channel   Direction  Beat contents
// in_       sink       tdata[0] restart
// out_      source     tdata: pos_x, pos_y, pos_z, tex_u, tex_v, normals, tangents;
//                      tlast last_vertex
// cfg_      APB slave  six registers at byte addresses 0, 4, ... 20
//
// Work on one vertex, from input beat to output beat: a capture, then four
// 40-step restoring divisions on a shared divider, each with a load and a save,
// then a load of the output register.
// Reset is synchronous and active low; it restores the register defaults and
// returns the walk to the first vertex of the +X face.
// A new input beat is taken while the previous result still waits downstream.
module cuboid_grid_vertex_generator #(
  parameter int MAX_GRID = cgv_pkg::MaxGridDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [112:96] tex_u, [129:113] tex_v,
  // [131:130] normal_x, [133:132] normal_y, [135:134] normal_z,
  // [137:136] tangent_x, [139:138] tangent_z
  output logic [143:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cgv_pkg::cmd_t cmd;
  cgv_pkg::cfg_t cfg;
  logic [31:0]   pos_x, pos_y, pos_z;
  logic [16:0]   tex_u, tex_v;
  logic [1:0]    normal_x, normal_y, normal_z, tangent_x, tangent_z;

  cgv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  cgv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .cmd        (cmd)
  );

  cgv_dp #(
    .MAX_GRID (MAX_GRID)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .tangent_x   (tangent_x),
    .tangent_z   (tangent_z),
    .last_vertex (out_tlast)
  );

  // Pack the result beat, first field in the lowest bits.
  assign out_tdata = {4'd0, tangent_z, tangent_x, normal_z, normal_y, normal_x,
                      tex_v, tex_u, pos_z, pos_y, pos_x};

endmodule

[sv/cgv_checker.sv]
module cgv_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tlast,
  input logic         cfg_pready
);

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // The controller leaves idle on each accepted beat, so no beat is taken right after another.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // The final vertex belongs to the -Z face.
  a_last_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[135:134] == 2'b11)
    else $error("last vertex not on the -Z face");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port stalled");

endmodule

bind cuboid_grid_vertex_generator cgv_checker u_cgv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

[sim/tb_cuboid_grid_vertex_generator.sv]
`timescale 1ns / 100ps

module tb_cuboid_grid_vertex_generator;

  localparam int  VertexLatency = 170;
  localparam longint CycleLimit = 64'd3000000;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [1:0]  normal_x;
    logic [1:0]  normal_y;
    logic [1:0]  normal_z;
    logic [1:0]  tangent_x;
    logic [1:0]  tangent_z;
    logic        last_vertex;
  } vertex_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Predictor copy of the configuration and walk state.
  logic [30:0] ext_x, ext_y, ext_z;
  logic [15:0] res_yz, res_xz, res_xy;
  int unsigned walk_face, walk_row, walk_col;

  vertex_t expected_vertices[$];
  int  error_count;
  longint cycle_count;
  bit  sink_no_idle;
  bit  sender_no_idle;
  int  sink_hold_cycles;

  cuboid_grid_vertex_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("** cuboid_grid_vertex_generator: FAILED **");
        $finish;
      end
    end
  end

  function automatic int unsigned clamp_grid(int unsigned n);
    if (n < 2) return 2;
    if (n > 255) return 255;
    return n;
  endfunction

  // Grid coordinate rounded to nearest, ties away from zero.
  function automatic longint grid_pos(int unsigned k, int unsigned n, longint e);
    longint num, den;
    num = (2 * longint'(k) - longint'(n - 1)) * e;
    den = 2 * longint'(n - 1);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  // Texture fraction rounded to nearest, ties upward.
  function automatic longint tex_coord(int unsigned k, int unsigned n);
    longint d;
    d = longint'(n - 1);
    return (longint'(k) * 131072 + d) / (2 * d);
  endfunction

  // Work out the vertex for one accepted request and advance the walk.
  function automatic vertex_t next_vertex(logic restart);
    vertex_t v;
    int unsigned face, cols, rows, r, c, i, j;
    logic [15:0] res;
    longint ew, eh, en, a, b, plane, fu, fv, tu, tv;
    if (restart) begin
      walk_face = 0; walk_row = 0; walk_col = 0;
    end
    face = (walk_face > 5) ? 0 : walk_face;
    if (face < 2) begin
      res = res_yz; ew = longint'(ext_y); eh = longint'(ext_z); en = longint'(ext_x);
    end else if (face < 4) begin
      res = res_xz; ew = longint'(ext_x); eh = longint'(ext_z); en = longint'(ext_y);
    end else begin
      res = res_xy; ew = longint'(ext_x); eh = longint'(ext_y); en = longint'(ext_z);
    end
    cols = clamp_grid(32'(res[7:0]));
    rows = clamp_grid(32'(res[15:8]));
    r = (walk_row > rows - 1) ? rows - 1 : walk_row;
    c = (walk_col > cols - 1) ? cols - 1 : walk_col;
    j = (face == 1 || face == 2) ? rows - 1 - r : r;
    i = (face == 5) ? cols - 1 - c : c;
    a = grid_pos(i, cols, ew);
    b = grid_pos(j, rows, eh);
    plane = (en + 1) / 2;
    if (face[0]) plane = -plane;
    fu = tex_coord(i, cols);
    fv = tex_coord(j, rows);
    tu = fu; tv = fv;
    v = '0;
    v.pos_x = 32'(a); v.pos_y = 32'(b); v.pos_z = 32'(plane);
    case (face)
      0: begin
        v.pos_x = 32'(plane); v.pos_y = 32'(a); v.pos_z = 32'(b);
        tu = tex_coord(rows - 1 - j, rows); tv = fu;
        v.normal_x = 2'b01; v.tangent_z = 2'b11;
      end
      1: begin
        v.pos_x = 32'(plane); v.pos_y = 32'(a); v.pos_z = 32'(b);
        tu = fv; tv = fu;
        v.normal_x = 2'b11; v.tangent_z = 2'b01;
      end
      2: begin
        v.pos_x = 32'(a); v.pos_y = 32'(plane); v.pos_z = 32'(b);
        tv = tex_coord(rows - 1 - j, rows);
        v.normal_y = 2'b01; v.tangent_x = 2'b01;
      end
      3: begin
        v.pos_x = 32'(a); v.pos_y = 32'(plane); v.pos_z = 32'(b);
        v.normal_y = 2'b11; v.tangent_x = 2'b01;
      end
      4: begin
        v.normal_z = 2'b01; v.tangent_x = 2'b01;
      end
      default: begin
        tu = tex_coord(cols - 1 - i, cols);
        v.normal_z = 2'b11; v.tangent_x = 2'b11;
      end
    endcase
    v.tex_u = 17'(tu);
    v.tex_v = 17'(tv);
    v.last_vertex = (face == 5) && (r + 1 >= rows) && (c + 1 >= cols);
    if (c + 1 < cols) begin
      walk_col = c + 1; walk_row = r; walk_face = face;
    end else if (r + 1 < rows) begin
      walk_col = 0; walk_row = r + 1; walk_face = face;
    end else begin
      walk_col = 0; walk_row = 0; walk_face = (face >= 5) ? 0 : face + 1;
    end
    return v;
  endfunction

  // Sink side: random stalls, optional long hold-off.
  initial begin
    out_tready = 1'b0;
    sink_hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= sink_no_idle || ($urandom_range(99) >= 16);
      end
    end
  end

  // Check each accepted output beat against the oldest expectation.
  initial begin
    vertex_t got, want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.pos_x       = out_tdata[31:0];
        got.pos_y       = out_tdata[63:32];
        got.pos_z       = out_tdata[95:64];
        got.tex_u       = out_tdata[112:96];
        got.tex_v       = out_tdata[129:113];
        got.normal_x    = out_tdata[131:130];
        got.normal_y    = out_tdata[133:132];
        got.normal_z    = out_tdata[135:134];
        got.tangent_x   = out_tdata[137:136];
        got.tangent_z   = out_tdata[139:138];
        got.last_vertex = out_tlast;
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected output beat %h", $time, got);
          error_count++;
        end else begin
          want = expected_vertices.pop_front();
          if (got.pos_x !== want.pos_x)
            $display("%0t: pos_x exp %h got %h", $time, want.pos_x, got.pos_x);
          if (got.pos_y !== want.pos_y)
            $display("%0t: pos_y exp %h got %h", $time, want.pos_y, got.pos_y);
          if (got.pos_z !== want.pos_z)
            $display("%0t: pos_z exp %h got %h", $time, want.pos_z, got.pos_z);
          if (got.tex_u !== want.tex_u)
            $display("%0t: tex_u exp %h got %h", $time, want.tex_u, got.tex_u);
          if (got.tex_v !== want.tex_v)
            $display("%0t: tex_v exp %h got %h", $time, want.tex_v, got.tex_v);
          if (got.normal_x !== want.normal_x)
            $display("%0t: normal_x exp %h got %h", $time, want.normal_x, got.normal_x);
          if (got.normal_y !== want.normal_y)
            $display("%0t: normal_y exp %h got %h", $time, want.normal_y, got.normal_y);
          if (got.normal_z !== want.normal_z)
            $display("%0t: normal_z exp %h got %h", $time, want.normal_z, got.normal_z);
          if (got.tangent_x !== want.tangent_x)
            $display("%0t: tangent_x exp %h got %h", $time, want.tangent_x, got.tangent_x);
          if (got.tangent_z !== want.tangent_z)
            $display("%0t: tangent_z exp %h got %h", $time, want.tangent_z, got.tangent_z);
          if (got.last_vertex !== want.last_vertex)
            $display("%0t: last_vertex exp %b got %b", $time, want.last_vertex,
                     got.last_vertex);
          if (got !== want) error_count++;
        end
      end
    end
  end

  // Send one request beat, with a random idle gap before it. The valid line
  // is left high after the beat; the next request or the drain sets it.
  task automatic send_request(logic restart);
    while (!sender_no_idle && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'($urandom_range(127)), restart};
    do @(posedge clk); while (!in_tready);
    expected_vertices.push_back(next_vertex(restart));
  endtask

  // Wait until every expected vertex has come out, plus settle time.
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (VertexLatency + 10) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (index)
      cgv_pkg::REG_X_EXT:  ext_x = value[30:0];
      cgv_pkg::REG_Y_EXT:  ext_y = value[30:0];
      cgv_pkg::REG_Z_EXT:  ext_z = value[30:0];
      cgv_pkg::REG_YZ_RES: res_yz = value[15:0];
      cgv_pkg::REG_XZ_RES: res_xz = value[15:0];
      default:             res_xy = value[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_cuboid(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] ryz, logic [31:0] rxz, logic [31:0] rxy);
    write_register(cgv_pkg::REG_X_EXT, x);
    write_register(cgv_pkg::REG_Y_EXT, y);
    write_register(cgv_pkg::REG_Z_EXT, z);
    write_register(cgv_pkg::REG_YZ_RES, ryz);
    write_register(cgv_pkg::REG_XZ_RES, rxz);
    write_register(cgv_pkg::REG_XY_RES, rxy);
  endtask

  // Walk the whole default cuboid once and on through the wrap.
  task automatic test_default_walk();
    repeat (25) send_request(1'b0);
    drain_outputs();
  endtask

  // Extreme extents, clamped grid sizes and restart mid-walk.
  task automatic test_extremes();
    set_cuboid(32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0000_0000, 32'h0000_FFFF, 32'h0000_0203);
    send_request(1'b1);
    repeat (10) send_request(1'b0);
    send_request(1'b1);
    repeat (12) send_request(1'b0);
    drain_outputs();
  endtask

  // Shrink the grid in the middle of a face.
  task automatic test_grid_shrink();
    set_cuboid(32'h0003_0000, 32'h0001_8001, 32'h7FFF_FFFF, 32'h0505, 32'h0302, 32'h0204);
    send_request(1'b1);
    repeat (14) send_request(1'b0);
    drain_outputs();
    write_register(cgv_pkg::REG_YZ_RES, 32'h0202);
    repeat (10) send_request(1'b0);
    drain_outputs();
  endtask

  // Long sink hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    sink_hold_cycles = 3 * VertexLatency;
    repeat (8) send_request(1'b0);
    drain_outputs();
  endtask

  // Random phases over several random configurations.
  task automatic test_random(int beats);
    int n;
    for (int phase = 0; phase < 5; phase++) begin
      set_cuboid($urandom, $urandom, $urandom,
                 ($urandom_range(5) << 8) | $urandom_range(6),
                 ($urandom_range(5) << 8) | $urandom_range(6),
                 $urandom);
      sender_no_idle = (phase == 2);
      sink_no_idle   = (phase == 2);
      n = beats / 5;
      for (int k = 0; k < n; k++)
        send_request($urandom_range(99) < 4);
      drain_outputs();
    end
    sender_no_idle = 1'b0;
    sink_no_idle   = 1'b0;
  endtask

  initial begin
    error_count = 0;
    sink_no_idle = 1'b0;
    sender_no_idle = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    ext_x = 31'd65536; ext_y = 31'd65536; ext_z = 31'd65536;
    res_yz = 16'd514; res_xz = 16'd514; res_xy = 16'd514;
    walk_face = 0; walk_row = 0; walk_col = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_walk();
    test_extremes();
    test_grid_shrink();
    test_backpressure();
    test_random(500);

    if (error_count == 0 && expected_vertices.size() == 0)
      $display("** cuboid_grid_vertex_generator: PASSED **");
    else
      $display("** cuboid_grid_vertex_generator: FAILED **");
    $finish;
  end

endmodule

[cuboid_grid_vertex_generator.f]
sv/cgv_pkg.sv
sv/cgv_regs.sv
sv/cgv_ctrl.sv
sv/cgv_dp.sv
sv/cuboid_grid_vertex_generator.sv
sv/cgv_checker.sv
sim/tb_cuboid_grid_vertex_generator.sv
